>>> hdl/jse_pkg.sv
// Package for the JSON string escaper with UTF-8 check.
// Holds the token type passed from front to back and the byte tables.
// No dependencies.
package jse_pkg;

   localparam int PLAN_DEPTH = 6;
   localparam int FIFO_DEPTH = 4;

   localparam logic [7:0] CH_QUOTE = 8'h22;
   localparam logic [7:0] CH_BSLASH = 8'h5c;
   localparam logic [7:0] CH_BS = 8'h08;
   localparam logic [7:0] CH_FF = 8'h0c;
   localparam logic [7:0] CH_LF = 8'h0a;
   localparam logic [7:0] CH_CR = 8'h0d;
   localparam logic [7:0] CH_TAB = 8'h09;
   localparam logic [7:0] CH_LOW_B = 8'h62;
   localparam logic [7:0] CH_LOW_F = 8'h66;
   localparam logic [7:0] CH_LOW_N = 8'h6e;
   localparam logic [7:0] CH_LOW_R = 8'h72;
   localparam logic [7:0] CH_LOW_T = 8'h74;
   localparam logic [7:0] CH_LOW_U = 8'h75;
   localparam logic [7:0] CH_LOW_D = 8'h64;
   localparam logic [7:0] CH_ZERO = 8'h30;
   localparam logic [7:0] CH_LOW_A = 8'h61;

   typedef enum logic [2:0] {
      TK_OPEN  = 3'd0,
      TK_CLOSE = 3'd1,
      TK_ESC   = 3'd2,
      TK_RAW   = 3'd3,
      TK_REPL  = 3'd4
   } tok_kind_type;

   typedef struct packed {
      tok_kind_type kind;
      logic [7:0]   data;
   } tok_type;

   function automatic logic [2:0] lead_len(input logic [7:0] b);
      logic [2:0] n;
      n = 3'd0;
      if (b >= 8'hc2 && b <= 8'hdf) n = 3'd2;
      else if (b >= 8'he0 && b <= 8'hef) n = 3'd3;
      else if (b >= 8'hf0 && b <= 8'hf4) n = 3'd4;
      return n;
   endfunction

   function automatic logic second_ok(input logic [7:0] lead, input logic [7:0] b);
      logic ok;
      case (lead)
         8'he0: ok = (b >= 8'ha0) && (b <= 8'hbf);
         8'hed: ok = (b >= 8'h80) && (b <= 8'h9f);
         8'hf0: ok = (b >= 8'h90) && (b <= 8'hbf);
         8'hf4: ok = (b >= 8'h80) && (b <= 8'h8f);
         default: ok = (b[7:6] == 2'b10);
      endcase
      return ok;
   endfunction

   function automatic logic [7:0] short_esc(input logic [7:0] b);
      logic [7:0] c;
      case (b)
         CH_QUOTE: c = CH_QUOTE;
         CH_BSLASH: c = CH_BSLASH;
         CH_BS: c = CH_LOW_B;
         CH_FF: c = CH_LOW_F;
         CH_LF: c = CH_LOW_N;
         CH_CR: c = CH_LOW_R;
         CH_TAB: c = CH_LOW_T;
         default: c = 8'h00;
      endcase
      return c;
   endfunction

   function automatic logic [7:0] hex_char(input logic [3:0] v);
      logic [7:0] c;
      if (v < 4'd10) c = CH_ZERO + {4'h0, v};
      else c = CH_LOW_A + {4'h0, v - 4'd10};
      return c;
   endfunction

   function automatic logic [2:0] tok_len(input tok_type t);
      logic [2:0] n;
      case (t.kind)
         TK_REPL: n = 3'd6;
         TK_ESC: begin
            if (short_esc(t.data) != 8'h00) n = 3'd2;
            else if (t.data < 8'h20) n = 3'd6;
            else n = 3'd1;
         end
         default: n = 3'd1;
      endcase
      return n;
   endfunction

   function automatic logic [7:0] tok_byte(input tok_type t, input logic [2:0] idx);
      logic [7:0] c;
      c = 8'h00;
      case (t.kind)
         TK_OPEN, TK_CLOSE: c = CH_QUOTE;
         TK_RAW: c = t.data;
         TK_REPL: begin
            case (idx)
               3'd0: c = CH_BSLASH;
               3'd1: c = CH_LOW_U;
               3'd5: c = CH_LOW_D;
               default: c = CH_LOW_F;
            endcase
         end
         TK_ESC: begin
            if (short_esc(t.data) != 8'h00) begin
               c = (idx == 3'd0) ? CH_BSLASH : short_esc(t.data);
            end else if (t.data < 8'h20) begin
               case (idx)
                  3'd0: c = CH_BSLASH;
                  3'd1: c = CH_LOW_U;
                  3'd4: c = hex_char(t.data[7:4]);
                  3'd5: c = hex_char(t.data[3:0]);
                  default: c = CH_ZERO;
               endcase
            end else begin
               c = t.data;
            end
         end
         default: c = 8'h00;
      endcase
      return c;
   endfunction

endpackage

>>> hdl/jse_front.sv
// Front end: accepts string bytes, tracks the open UTF-8 sequence and
// turns each beat into a short list of tokens pushed one per cycle while the
// token queue has room. Depends on jse_pkg.
module jse_front
   import jse_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_data_byte,
   input  logic       req_byte_present,
   input  logic       req_first_of_string,
   input  logic       req_last_of_string,
   output logic       push_valid,
   output tok_type    push_tok,
   input  logic       push_ready
);

   logic [7:0] lead_ff, lead_in;
   logic [7:0] tail_ff [2];
   logic [7:0] tail_in [2];
   logic [1:0] cnt_ff, cnt_in;
   logic [2:0] need_ff, need_in;

   tok_type    plan_ff [PLAN_DEPTH];
   tok_type    plan_in [PLAN_DEPTH];
   logic [2:0] plan_cnt_ff, plan_cnt_in;
   logic [2:0] idx_ff;
   logic       busy_ff;

   logic       accept, push_fire, push_done;
   logic [1:0] p;
   logic       ok, start;
   logic [7:0] b;

   assign push_valid = busy_ff;
   assign push_tok   = plan_ff[idx_ff];
   assign push_fire  = busy_ff && push_ready;
   assign push_done  = push_fire && (idx_ff == plan_cnt_ff - 3'd1);
   assign req_stall  = busy_ff && !push_done;
   assign accept     = req_valid && !req_stall;

   always_comb begin
      lead_in    = lead_ff;
      tail_in[0] = tail_ff[0];
      tail_in[1] = tail_ff[1];
      cnt_in     = cnt_ff;
      need_in    = need_ff;
      for (int i = 0; i < PLAN_DEPTH; i++) plan_in[i] = '{TK_RAW, 8'h00};
      plan_cnt_in = 3'd0;
      b     = req_data_byte;
      start = 1'b0;
      ok    = 1'b0;
      p     = cnt_ff;

      if (req_first_of_string) begin
         p = 2'd0;
         need_in = 3'd0;
         plan_in[plan_cnt_in] = '{TK_OPEN, CH_QUOTE};
         plan_cnt_in = plan_cnt_in + 3'd1;
      end

      if (req_byte_present) begin
         if (p != 2'd0) begin
            ok = (p == 2'd1) ? second_ok(lead_ff, b) : (b[7:6] == 2'b10);
            if (ok) begin
               if ({1'b0, p} + 3'd1 >= need_ff) begin
                  plan_in[plan_cnt_in] = '{TK_RAW, lead_ff};
                  plan_cnt_in = plan_cnt_in + 3'd1;
                  if (p >= 2'd2) begin
                     plan_in[plan_cnt_in] = '{TK_RAW, tail_ff[0]};
                     plan_cnt_in = plan_cnt_in + 3'd1;
                  end
                  if (p == 2'd3) begin
                     plan_in[plan_cnt_in] = '{TK_RAW, tail_ff[1]};
                     plan_cnt_in = plan_cnt_in + 3'd1;
                  end
                  plan_in[plan_cnt_in] = '{TK_RAW, b};
                  plan_cnt_in = plan_cnt_in + 3'd1;
                  p = 2'd0;
                  need_in = 3'd0;
               end else begin
                  if (p == 2'd1) tail_in[0] = b;
                  else tail_in[1] = b;
                  p = p + 2'd1;
               end
            end else begin
               // lead plus each held continuation byte becomes a replacement
               for (int i = 0; i < 3; i++) begin
                  if (i < int'(p)) begin
                     plan_in[plan_cnt_in] = '{TK_REPL, 8'h00};
                     plan_cnt_in = plan_cnt_in + 3'd1;
                  end
               end
               p = 2'd0;
               need_in = 3'd0;
               start = 1'b1;
            end
         end else begin
            start = 1'b1;
         end
      end

      if (start) begin
         if (!b[7]) begin
            plan_in[plan_cnt_in] = '{TK_ESC, b};
            plan_cnt_in = plan_cnt_in + 3'd1;
         end else if (lead_len(b) == 3'd0) begin
            plan_in[plan_cnt_in] = '{TK_REPL, 8'h00};
            plan_cnt_in = plan_cnt_in + 3'd1;
         end else begin
            lead_in = b;
            need_in = lead_len(b);
            p = 2'd1;
         end
      end

      if (req_last_of_string) begin
         for (int i = 0; i < 3; i++) begin
            if (i < int'(p)) begin
               plan_in[plan_cnt_in] = '{TK_REPL, 8'h00};
               plan_cnt_in = plan_cnt_in + 3'd1;
            end
         end
         p = 2'd0;
         need_in = 3'd0;
         plan_in[plan_cnt_in] = '{TK_CLOSE, CH_QUOTE};
         plan_cnt_in = plan_cnt_in + 3'd1;
      end

      cnt_in = p;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lead_ff <= 8'h00;
         cnt_ff  <= 2'd0;
         need_ff <= 3'd0;
         busy_ff <= 1'b0;
         idx_ff  <= 3'd0;
         plan_cnt_ff <= 3'd0;
      end else begin
         if (accept) begin
            lead_ff <= lead_in;
            cnt_ff  <= cnt_in;
            need_ff <= need_in;
            busy_ff <= (plan_cnt_in != 3'd0);
            idx_ff  <= 3'd0;
            plan_cnt_ff <= plan_cnt_in;
         end else if (push_done) begin
            busy_ff <= 1'b0;
         end else if (push_fire) begin
            idx_ff <= idx_ff + 3'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         tail_ff[0] <= tail_in[0];
         tail_ff[1] <= tail_in[1];
         for (int i = 0; i < PLAN_DEPTH; i++) plan_ff[i] <= plan_in[i];
      end
   end

endmodule

>>> hdl/jse_fifo.sv
// Four-entry token queue between front and back end.
// Depends on jse_pkg.
module jse_fifo
   import jse_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push_valid,
   input  tok_type push_tok,
   output logic    push_ready,
   output logic    pop_valid,
   output tok_type pop_tok,
   input  logic    pop_ready
);

   localparam int AW = $clog2(FIFO_DEPTH);

   tok_type         mem_ff [FIFO_DEPTH];
   logic [AW-1:0]   wr_ff, rd_ff;
   logic [AW:0]     cnt_ff;
   logic            do_push, do_pop;

   assign push_ready = (cnt_ff != (AW+1)'(FIFO_DEPTH));
   assign pop_valid  = (cnt_ff != '0);
   assign pop_tok    = mem_ff[rd_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (do_push) wr_ff <= wr_ff + AW'(1);
         if (do_pop) rd_ff <= rd_ff + AW'(1);
         if (do_push && !do_pop) cnt_ff <= cnt_ff + (AW+1)'(1);
         else if (do_pop && !do_push) cnt_ff <= cnt_ff - (AW+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) mem_ff[wr_ff] <= push_tok;
   end

endmodule

>>> hdl/jse_back.sv
// Back end: expands each token into its output bytes, one per cycle while the
// receiver does not stall, into a registered result stage. Depends on jse_pkg.
module jse_back
   import jse_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       pop_valid,
   input  tok_type    pop_tok,
   output logic       pop_ready,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_out_last
);

   tok_type    cur_ff;
   logic [2:0] idx_ff;
   logic       busy_ff;
   logic       rsp_valid_ff;
   logic [7:0] byte_ff;
   logic       last_ff;
   logic       adv, done;

   assign adv       = busy_ff && (!rsp_valid_ff || !rsp_stall);
   assign done      = adv && (idx_ff == tok_len(cur_ff) - 3'd1);
   assign pop_ready = !busy_ff || done;

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_out_byte = byte_ff;
   assign rsp_out_last = last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         idx_ff       <= 3'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (pop_valid && pop_ready) begin
            busy_ff <= 1'b1;
            idx_ff  <= 3'd0;
         end else if (done) begin
            busy_ff <= 1'b0;
         end else if (adv) begin
            idx_ff <= idx_ff + 3'd1;
         end
         if (adv) rsp_valid_ff <= 1'b1;
         else if (!rsp_stall) rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (pop_valid && pop_ready) cur_ff <= pop_tok;
      if (adv) begin
         byte_ff <= tok_byte(cur_ff, idx_ff);
         last_ff <= (cur_ff.kind == TK_CLOSE);
      end
   end

endmodule

>>> hdl/json_string_escaper_utf8_check_top.sv
// Each beat carries at most one raw string byte and leaves as JSON text, one
// byte per result beat, with quotes, short and \u00XX escapes, and \ufffd for
// every byte of a malformed or truncated UTF-8 sequence. The front end takes a
// beat and then pushes its tokens (quote, escaped byte, copied byte, replacement)
// in turn into a four-entry token queue, taking the next beat as its last token
// is pushed; the back end emits one output byte per cycle while the receiver does
// not stall, so sustained throughput is one result byte per cycle and a beat can
// produce up to 25 output bytes. There is no clearing pass after reset.
module json_string_escaper_utf8_check_top
   import jse_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_data_byte,
   input  logic       req_byte_present,
   input  logic       req_first_of_string,
   input  logic       req_last_of_string,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_out_last
);

   logic    f_valid, f_ready, b_valid, b_ready;
   tok_type f_tok, b_tok;

   jse_front u_front (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_data_byte       (req_data_byte),
      .req_byte_present    (req_byte_present),
      .req_first_of_string (req_first_of_string),
      .req_last_of_string  (req_last_of_string),
      .push_valid          (f_valid),
      .push_tok            (f_tok),
      .push_ready          (f_ready)
   );

   jse_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (f_valid),
      .push_tok   (f_tok),
      .push_ready (f_ready),
      .pop_valid  (b_valid),
      .pop_tok    (b_tok),
      .pop_ready  (b_ready)
   );

   jse_back u_back (
      .clock        (clock),
      .reset        (reset),
      .pop_valid    (b_valid),
      .pop_tok      (b_tok),
      .pop_ready    (b_ready),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_out_byte (rsp_out_byte),
      .rsp_out_last (rsp_out_last)
   );

endmodule

>>> bench/tb_json_string_escaper_utf8_check_top.sv
`timescale 1ns / 1ps
// Testbench for json_string_escaper_utf8_check_top: random strings of ASCII, good and broken
// UTF-8 go in one beat at a time; a built-in escaper predicts the quoted JSON bytes.
// Depends on jse_pkg for the character constants.
module tb_json_string_escaper_utf8_check_top;
   import jse_pkg::*;

   localparam int TIMEOUT_NS = 6_400_000;

   typedef struct packed {
      logic [7:0] data;
      logic       present;
      logic       first;
      logic       last;
   } str_beat_type;

   typedef struct packed {
      logic [7:0] ch;
      logic       last;
   } json_char_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [7:0] req_data_byte = 8'h00;
   logic       req_byte_present = 1'b0;
   logic       req_first_of_string = 1'b0;
   logic       req_last_of_string = 1'b0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [7:0] rsp_out_byte;
   logic       rsp_out_last;

   str_beat_type  raw_beats[$];
   json_char_type text_due[$];
   logic [7:0]    str_bytes[$];

   // escaper state
   logic [7:0] pend_lead = 8'h00;
   logic [7:0] pend_tail[2];
   logic [1:0] pend_cnt = 2'd0;
   logic [2:0] need_len = 3'd0;

   int         planned = 0;
   int         strings_made = 0;
   int         total_beats = 0;
   int         beats_taken = 0;
   int         bytes_seen = 0;
   int         errors = 0;
   int         src_gap = 0;
   int         src_run = 0;
   bit         src_calm = 1'b0;
   int         snk_gap = 0;
   int         snk_run = 0;
   bit         snk_calm = 1'b0;
   logic       hold_on = 1'b0;
   int         hold_left = 0;
   int         holds_done = 0;
   str_beat_type  next_beat;
   json_char_type want;

   json_string_escaper_utf8_check_top dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_data_byte       (req_data_byte),
      .req_byte_present    (req_byte_present),
      .req_first_of_string (req_first_of_string),
      .req_last_of_string  (req_last_of_string),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_out_byte        (rsp_out_byte),
      .rsp_out_last        (rsp_out_last)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // ---------------- escaper prediction ----------------

   task automatic put_char(input logic [7:0] ch, input logic last);
      json_char_type c;
      c.ch = ch;
      c.last = last;
      text_due = {text_due, c};
   endtask

   task automatic put_repl();
      put_char(CH_BSLASH, 1'b0);
      put_char(CH_LOW_U, 1'b0);
      put_char(CH_LOW_F, 1'b0);
      put_char(CH_LOW_F, 1'b0);
      put_char(CH_LOW_F, 1'b0);
      put_char(CH_LOW_D, 1'b0);
   endtask

   function automatic logic [7:0] hex_digit(input logic [3:0] n);
      if (n < 4'd10) return CH_ZERO + 8'(n);
      return CH_LOW_A + 8'(n) - 8'd10;
   endfunction

   task automatic put_escaped(input logic [7:0] b);
      case (b)
         CH_QUOTE, CH_BSLASH: begin
            put_char(CH_BSLASH, 1'b0);
            put_char(b, 1'b0);
         end
         CH_BS: begin
            put_char(CH_BSLASH, 1'b0);
            put_char(CH_LOW_B, 1'b0);
         end
         CH_FF: begin
            put_char(CH_BSLASH, 1'b0);
            put_char(CH_LOW_F, 1'b0);
         end
         CH_LF: begin
            put_char(CH_BSLASH, 1'b0);
            put_char(CH_LOW_N, 1'b0);
         end
         CH_CR: begin
            put_char(CH_BSLASH, 1'b0);
            put_char(CH_LOW_R, 1'b0);
         end
         CH_TAB: begin
            put_char(CH_BSLASH, 1'b0);
            put_char(CH_LOW_T, 1'b0);
         end
         default: begin
            if (b < 8'h20) begin
               put_char(CH_BSLASH, 1'b0);
               put_char(CH_LOW_U, 1'b0);
               put_char(CH_ZERO, 1'b0);
               put_char(CH_ZERO, 1'b0);
               put_char(hex_digit(b[7:4]), 1'b0);
               put_char(hex_digit(b[3:0]), 1'b0);
            end else begin
               put_char(b, 1'b0);
            end
         end
      endcase
   endtask

   function automatic logic [2:0] utf8_len(input logic [7:0] b);
      if (b >= 8'hc2 && b <= 8'hdf) return 3'd2;
      if (b >= 8'he0 && b <= 8'hef) return 3'd3;
      if (b >= 8'hf0 && b <= 8'hf4) return 3'd4;
      return 3'd0;
   endfunction

   function automatic logic second_fits(input logic [7:0] lead, input logic [7:0] b);
      case (lead)
         8'he0: return b >= 8'ha0 && b <= 8'hbf;
         8'hed: return b >= 8'h80 && b <= 8'h9f;
         8'hf0: return b >= 8'h90 && b <= 8'hbf;
         8'hf4: return b >= 8'h80 && b <= 8'h8f;
         default: return b[7:6] == 2'b10;
      endcase
   endfunction

   task automatic fresh_byte(input logic [7:0] b);
      if (b < 8'h80) begin
         put_escaped(b);
      end else if (utf8_len(b) == 3'd0) begin
         put_repl();
      end else begin
         pend_lead = b;
         need_len = utf8_len(b);
         pend_cnt = 2'd1;
      end
   endtask

   task automatic follow_byte(input logic [7:0] b);
      logic [1:0] held;
      logic       ok;
      logic [7:0] saved[2];
      held = pend_cnt - 2'd1;
      ok = (pend_cnt == 2'd1) ? second_fits(pend_lead, b) : (b[7:6] == 2'b10);
      if (ok) begin
         if ({1'b0, pend_cnt} + 3'd1 >= need_len) begin
            put_char(pend_lead, 1'b0);
            for (int i = 0; i < held; i++) put_char(pend_tail[i], 1'b0);
            put_char(b, 1'b0);
            pend_cnt = 2'd0;
            need_len = 3'd0;
         end else begin
            pend_tail[held[0]] = b;
            pend_cnt = pend_cnt + 2'd1;
         end
      end else begin
         saved[0] = pend_tail[0];
         saved[1] = pend_tail[1];
         pend_cnt = 2'd0;
         need_len = 3'd0;
         put_repl();
         for (int i = 0; i < held; i++) fresh_byte(saved[i]);
         fresh_byte(b);
      end
   endtask

   task automatic escape_beat(input logic [7:0] b, input logic present, input logic first,
                              input logic last);
      if (first) begin
         pend_cnt = 2'd0;
         need_len = 3'd0;
         put_char(CH_QUOTE, 1'b0);
      end
      if (present) begin
         if (pend_cnt != 2'd0) follow_byte(b);
         else fresh_byte(b);
      end
      if (last) begin
         if (pend_cnt != 2'd0) begin
            put_repl();
            for (int i = 0; i < pend_cnt - 1; i++) put_repl();
            pend_cnt = 2'd0;
            need_len = 3'd0;
         end
         put_char(CH_QUOTE, 1'b1);
      end
   endtask

   // ---------------- stimulus building ----------------

   task automatic add_beat(input logic [7:0] b, input logic present, input logic first,
                           input logic last);
      str_beat_type s;
      s.data = b;
      s.present = present;
      s.first = first;
      s.last = last;
      raw_beats = {raw_beats, s};
      if (present || first || last) planned++;
   endtask

   task automatic add_string(input bit sf, input bit sl, input bit ab);
      int n;
      n = str_bytes.size();
      if (sf || n == 0) add_beat(8'($urandom), 1'b0, 1'b1, (n == 0) && !sl && !ab);
      for (int i = 0; i < n; i++)
         add_beat(str_bytes[i], 1'b1, (i == 0) && !sf, (i == n - 1) && !sl && !ab);
      if (sl && !ab) add_beat(8'($urandom), 1'b0, 1'b0, 1'b1);
      strings_made++;
      str_bytes.delete();
   endtask

   task automatic add_utf8(input int len);
      logic [7:0] lead;
      logic [7:0] nxt;
      int         r;
      r = $urandom_range(0, 3);
      case (len)
         2: lead = 8'($urandom_range(8'hc2, 8'hdf));
         3: lead = (r == 0) ? 8'he0 : (r == 1) ? 8'hed : 8'($urandom_range(8'he0, 8'hef));
         default: lead = (r == 0) ? 8'hf0 : (r == 1) ? 8'hf4 : 8'($urandom_range(8'hf0, 8'hf4));
      endcase
      case (lead)
         8'he0: nxt = 8'($urandom_range(8'ha0, 8'hbf));
         8'hed: nxt = 8'($urandom_range(8'h80, 8'h9f));
         8'hf0: nxt = 8'($urandom_range(8'h90, 8'hbf));
         8'hf4: nxt = 8'($urandom_range(8'h80, 8'h8f));
         default: nxt = 8'($urandom_range(8'h80, 8'hbf));
      endcase
      str_bytes = {str_bytes, lead, nxt};
      repeat (len - 2) str_bytes = {str_bytes, 8'($urandom_range(8'h80, 8'hbf))};
   endtask

   function automatic logic [7:0] bad_next(input logic [7:0] lead, input int keep);
      if (keep == 1 && $urandom_range(0, 1) == 1) begin
         case (lead)
            8'he0: return 8'($urandom_range(8'h80, 8'h9f));
            8'hed: return 8'($urandom_range(8'ha0, 8'hbf));
            8'hf0: return 8'($urandom_range(8'h80, 8'h8f));
            8'hf4: return 8'($urandom_range(8'h90, 8'hbf));
            default: ;
         endcase
      end
      if ($urandom_range(0, 1) == 1) return 8'($urandom_range(8'h00, 8'h7f));
      return 8'($urandom_range(8'hc0, 8'hff));
   endfunction

   function automatic logic [7:0] pick_ascii();
      case ($urandom_range(0, 3))
         0: return ($urandom_range(0, 1) == 1) ? CH_QUOTE : CH_BSLASH;
         1: return 8'($urandom_range(8'h00, 8'h1f));
         default: return 8'($urandom_range(8'h20, 8'h7f));
      endcase
   endfunction

   task automatic add_segment();
      int         kind;
      int         len;
      int         keep;
      logic [7:0] lead;
      kind = $urandom_range(0, 9);
      if (kind < 4) begin
         str_bytes = {str_bytes, pick_ascii()};
      end else if (kind < 7) begin
         add_utf8($urandom_range(2, 4));
      end else if (kind == 7) begin
         str_bytes = {str_bytes, ($urandom_range(0, 1) == 1) ? 8'($urandom_range(8'h80, 8'hc1))
                                                             : 8'($urandom_range(8'hf5, 8'hff))};
      end else begin
         len = $urandom_range(2, 4);
         add_utf8(len);
         keep = $urandom_range(1, len - 1);
         repeat (len - keep) void'(str_bytes.pop_back());
         lead = str_bytes[str_bytes.size() - keep];
         if (kind == 8) str_bytes = {str_bytes, bad_next(lead, keep)};
      end
   endtask

   function automatic int pick_gap(input bit calm);
      int r;
      r = $urandom_range(0, 99);
      if (calm || r < 55) return 0;
      if (r < 88) return $urandom_range(1, 3);
      return $urandom_range(6, 25);
   endfunction

   // ---------------- driver ----------------

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_data_byte <= 8'h00;
         req_byte_present <= 1'b0;
         req_first_of_string <= 1'b0;
         req_last_of_string <= 1'b0;
         pend_lead = 8'h00;
         pend_cnt = 2'd0;
         need_len = 3'd0;
         src_gap = 0;
      end else begin
         if (req_valid && !req_stall) begin
            escape_beat(req_data_byte, req_byte_present, req_first_of_string,
                        req_last_of_string);
            beats_taken++;
            src_gap = pick_gap(src_calm);
         end
         if (src_run == 0) begin
            src_calm = ($urandom_range(0, 3) == 0);
            src_run = $urandom_range(20, 60);
         end else begin
            src_run--;
         end
         if (!req_valid || !req_stall) begin
            if (src_gap != 0 || raw_beats.size() == 0) begin
               if (src_gap != 0) src_gap--;
               req_valid <= 1'b0;
            end else begin
               next_beat = raw_beats.pop_front();
               req_valid <= 1'b1;
               req_data_byte <= next_beat.data;
               req_byte_present <= next_beat.present;
               req_first_of_string <= next_beat.first;
               req_last_of_string <= next_beat.last;
            end
         end
      end
   end

   // ---------------- long receiver hold-off ----------------

   always @(posedge clock) begin
      if (reset) begin
         hold_on <= 1'b0;
         hold_left = 0;
         holds_done = 0;
      end else if (hold_left != 0) begin
         hold_left--;
         if (hold_left == 0) hold_on <= 1'b0;
      end else if ((holds_done == 0 && beats_taken >= 40) ||
                   (holds_done == 1 && beats_taken >= 140)) begin
         hold_on <= 1'b1;
         hold_left = 300;
         holds_done++;
      end
   end

   // ---------------- monitor ----------------

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         snk_gap = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            bytes_seen++;
            if (text_due.size() == 0) begin
               errors++;
               if (errors <= 10)
                  $display("unexpected output beat: byte %02h last %0b",
                           rsp_out_byte, rsp_out_last);
            end else begin
               want = text_due.pop_front();
               if (rsp_out_byte !== want.ch || rsp_out_last !== want.last) begin
                  errors++;
                  if (errors <= 10)
                     $display("mismatch at output %0d: byte %02h last %0b, expected %02h last %0b",
                              bytes_seen, rsp_out_byte, rsp_out_last, want.ch, want.last);
               end
            end
         end
         if (snk_run == 0) begin
            snk_calm = ($urandom_range(0, 3) == 0);
            snk_run = $urandom_range(20, 60);
         end else begin
            snk_run--;
         end
         if (snk_gap == 0 && !snk_calm && $urandom_range(0, 2) == 0) snk_gap = pick_gap(1'b0);
         rsp_stall <= hold_on || (snk_gap != 0);
         if (snk_gap != 0) snk_gap--;
      end
   end

   // ---------------- sequence ----------------

   initial begin
      int dir_items;

      add_string(1'b0, 1'b0, 1'b0);
      str_bytes = {8'h00, CH_QUOTE, CH_BSLASH, CH_BS, CH_FF, CH_LF, CH_CR, CH_TAB, 8'h7f, 8'h20};
      add_string(1'b0, 1'b0, 1'b0);
      str_bytes = {8'h80, 8'hff};
      add_string(1'b0, 1'b0, 1'b0);
      str_bytes = {8'he0, 8'ha0, 8'h80};
      add_string(1'b0, 1'b0, 1'b0);
      // two held continuation bytes, then a control byte breaks the sequence
      str_bytes = {8'hf4, 8'h8f, 8'hbf, 8'h1f};
      add_string(1'b0, 1'b0, 1'b0);
      // cut short by the end of the string
      str_bytes = {8'hf0, 8'h90, 8'h80};
      add_string(1'b0, 1'b0, 1'b0);
      // new string while a lead is still held
      str_bytes = {8'he1};
      add_string(1'b0, 1'b0, 1'b1);
      str_bytes = {8'h41};
      add_string(1'b0, 1'b0, 1'b0);
      dir_items = planned;

      while (planned < dir_items + 150) begin
         if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(1, 3))
               add_beat(8'($urandom), 1'($urandom), 1'($urandom), 1'($urandom));
         end else begin
            repeat ($urandom_range(0, 6)) add_segment();
            add_string($urandom_range(0, 4) == 0, $urandom_range(0, 4) == 0,
                       $urandom_range(0, 9) == 0);
         end
      end
      total_beats = raw_beats.size();

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      while (beats_taken < total_beats) @(posedge clock);
      while (text_due.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);

      $display("covered %0d input beats in %0d strings, %0d output bytes checked",
               beats_taken, strings_made, bytes_seen);
      $display("receiver hold-offs: %0d, failures: %0d", holds_done, errors);
      if (errors == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   initial begin
      #TIMEOUT_NS;
      $display("timeout: %0d of %0d beats taken, %0d output bytes still due",
               beats_taken, total_beats, text_due.size());
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule
